// ===== hdl/opfdt_pkg.sv =====
package opfdt_pkg;

    // Default depth of the distinct-address table.
    localparam int TABLE_DEPTH_DEF = 16;

    // Number of vendor prefixes stored in the ROM, and how many of them are searched.
    localparam int PREFIX_ROM_ENTRIES = 31;
    localparam int PREFIX_COUNT = 31;

    // Width of the distinct count as it is reported.
    localparam int DISTINCT_W = 5;

    // Command codes carried in the op field.
    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_PROBE = 1'b1;

    typedef struct packed {
        logic        op;
        logic [47:0] src_mac;
        logic        wildcard_ssid;
    } probe_item_t;

    typedef struct packed {
        logic                  prefix_hit;
        logic                  new_device;
        logic [15:0]           hit_total;
        logic [DISTINCT_W-1:0] distinct_total;
    } result_item_t;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        logic        is_clear;
        logic        is_hit;
        logic [47:0] mac;
    } cls_item_t;

    localparam logic [23:0] PREFIX_ROM [PREFIX_ROM_ENTRIES] = '{
        24'h70c94e, 24'h3c9180, 24'hd8f3bc, 24'h803049, 24'hb83532, 24'h145afc,
        24'h744ca1, 24'h083a88, 24'h9c2f9d, 24'hc03532, 24'h940853, 24'he4aaea,
        24'hf46add, 24'hf8a2d6, 24'h24b2b9, 24'h00f48d, 24'hd03957, 24'he8d0fc,
        24'he04f43, 24'hb81ea4, 24'h700894, 24'h588e81, 24'hec1bbd, 24'h3c71bf,
        24'h5800e3, 24'h9035ea, 24'h5c93a2, 24'h646e69, 24'h4827ea, 24'ha4cf12,
        24'h826bf2
    };

    // True when the upper three address bytes match one of the searched prefixes.
    function automatic logic prefix_listed(input logic [23:0] oui);
        logic found;
        found = 1'b0;
        for (int i = 0; i < PREFIX_ROM_ENTRIES; i++) begin
            if (i < PREFIX_COUNT && PREFIX_ROM[i] == oui) begin
                found = 1'b1;
            end
        end
        return found;
    endfunction

endpackage

// ===== hdl/opfdt_front.sv =====
module opfdt_front
    import opfdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        probe_valid,
    output logic        probe_stall,
    input  probe_item_t probe,
    output logic        push,
    output cls_item_t   push_item,
    input  logic        q_full
);

    logic      fr_valid_reg;
    logic      fr_valid_next;
    cls_item_t fr_item_reg;
    cls_item_t fr_item_next;
    logic      accept;

    // The holding register can take a new transfer unless its item is blocked by a full queue.
    assign probe_stall = fr_valid_reg && q_full;
    assign accept      = probe_valid && !probe_stall;
    assign push        = fr_valid_reg && !q_full;
    assign push_item   = fr_item_reg;

    always_comb
    begin
        fr_item_next.is_clear = (probe.op == OP_CLEAR);
        fr_item_next.is_hit   = (probe.op == OP_PROBE) && probe.wildcard_ssid
                                && prefix_listed(probe.src_mac[47:24]);
        fr_item_next.mac      = probe.src_mac;

        if (accept) begin
            fr_valid_next = 1'b1;
        end else if (push) begin
            fr_valid_next = 1'b0;
        end else begin
            fr_valid_next = fr_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fr_valid_reg <= 1'b0;
        end else begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            fr_item_reg <= fr_item_next;
        end
    end

    // A clear command is never classified as a hit.
    a_clear_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
        fr_valid_reg |-> !(fr_item_reg.is_clear && fr_item_reg.is_hit))
        else $error("front: clear item marked as hit");

endmodule

// ===== hdl/opfdt_queue.sv =====
module opfdt_queue
    import opfdt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cls_item_t push_item,
    output logic      full,
    output logic      q_valid,
    output cls_item_t q_item,
    input  logic      pop
);

    cls_item_t   mem_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // The pointers stay one apart exactly when one entry is held.
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg))
        else $error("queue: pointers disagree with count");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue: push into full queue");

endmodule

// ===== hdl/opfdt_back.sv =====
module opfdt_back
    import opfdt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  cls_item_t    q_item,
    output logic         pop,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [47:0]   table_reg [TABLE_DEPTH];
    logic [15:0]   hit_cnt_reg;
    logic [15:0]   hit_cnt_next;
    logic [CW-1:0] seen_cnt_reg;
    logic [CW-1:0] seen_cnt_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    result_item_t  out_item_reg;
    result_item_t  out_item_next;
    logic          match;
    logic          table_full;
    logic          store_en;

    assign pop          = q_valid && (!out_valid_reg || !result_stall);
    assign table_full   = (seen_cnt_reg == CW'(TABLE_DEPTH));
    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    // Only entries below the fill count are compared, so unwritten entries never count.
    always_comb
    begin
        match = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (CW'(i) < seen_cnt_reg && table_reg[i] == q_item.mac) begin
                match = 1'b1;
            end
        end
    end

    always_comb
    begin
        hit_cnt_next  = hit_cnt_reg;
        seen_cnt_next = seen_cnt_reg;
        store_en      = 1'b0;
        out_item_next.prefix_hit = 1'b0;
        out_item_next.new_device = 1'b0;

        if (q_item.is_clear) begin
            hit_cnt_next  = 16'd0;
            seen_cnt_next = '0;
        end else if (q_item.is_hit) begin
            hit_cnt_next = hit_cnt_reg + 16'd1;
            out_item_next.prefix_hit = 1'b1;
            out_item_next.new_device = !match;
            if (!match && !table_full) begin
                store_en      = pop;
                seen_cnt_next = seen_cnt_reg + CW'(1);
            end
        end

        out_item_next.hit_total      = hit_cnt_next;
        out_item_next.distinct_total = DISTINCT_W'(seen_cnt_next);

        if (pop) begin
            out_valid_next = 1'b1;
        end else if (!result_stall) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hit_cnt_reg   <= 16'd0;
            seen_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (pop) begin
                hit_cnt_reg  <= hit_cnt_next;
                seen_cnt_reg <= seen_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            out_item_reg <= out_item_next;
        end
        if (store_en) begin
            table_reg[seen_cnt_reg[IW-1:0]] <= q_item.mac;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_cnt_reg <= CW'(TABLE_DEPTH))
        else $error("back: distinct count beyond table depth");

    a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
        pop && q_item.is_clear |=> seen_cnt_reg == '0 && hit_cnt_reg == 16'd0)
        else $error("back: clear left counters set");

    a_new_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.new_device |-> out_item_reg.prefix_hit)
        else $error("back: new device without prefix hit");

endmodule

// ===== hdl/oui_probe_filter_distinct_tracker_unit.sv =====
// A probe accepted on a transfer is classified into a holding register, then enters
// the two-entry queue and from there lands in the result register.
// Throughput: one item per cycle while result_stall is low; table compare is combinational.
// Reset (rst_n, asynchronous, active low) empties the pipeline and zeroes the hit and
// distinct counters; stored addresses are not cleared, the fill count masks them instead.
module oui_probe_filter_distinct_tracker_unit
    import opfdt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         probe_valid,
    output logic         probe_stall,
    input  probe_item_t  probe,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result
);

    // Front end: takes each transfer and classifies it as a clear, a prefix hit or a miss.
    // The prefix ROM is searched in parallel against the upper three address bytes.
    logic      push;
    cls_item_t push_item;
    logic      q_full;
    logic      q_valid;
    cls_item_t q_item;
    logic      pop;

    opfdt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .probe_valid (probe_valid),
        .probe_stall (probe_stall),
        .probe       (probe),
        .push        (push),
        .push_item   (push_item),
        .q_full      (q_full)
    );

    // A short queue decouples the two halves, so a stalled result side does not
    // immediately stall the probe side.
    opfdt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop)
    );

    // Back end: owns the hit counter and the distinct-address table. A hit is
    // compared against every filled entry at once; an unseen address is appended
    // while room remains and is reported as new even when the table is full.
    // The result register holds one finished transfer while the next item is taken.
    opfdt_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
